>>> sv/olpht_pkg.sv
// Shared types, constants and helpers for the ordered linear-probe hash table.
// Used by the hash unit, the top level and the port checker.
`default_nettype none

package olpht_pkg;

	localparam int TABLE_SIZE_DEF = 1024;
	localparam int KEY_BYTES_DEF  = 8;

	localparam int KEY_W     = 64;
	localparam int HASH_W    = 64;
	localparam int VALUE_W   = 16;
	localparam int SLOT_W    = 10;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 32;
	localparam int M_PAD_W   = M_TDATA_W - SLOT_W - VALUE_W;

	localparam logic [31:0] HASH_MULT = 32'd2654435761;

	typedef enum logic [1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_FOUND     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_LOOKUP = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_START,
		ST_PROBE,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		HS_IDLE,
		HS_BYTE,
		HS_MUL_LO,
		HS_MUL_HI
	} hash_state_t;

	// one table slot as held in the entry memory
	typedef struct packed {
		logic               used;
		logic [HASH_W-1:0]  hash;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} ent_t;

	// keep the bytes before the first zero byte, at most nbytes of them
	function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] k, input int nbytes);
		logic             keep;
		logic [KEY_W-1:0] r;
		r    = '0;
		keep = 1'b1;
		for (int i = 0; i < KEY_W / 8; i++) begin
			if (k[8*i +: 8] == 8'd0 || i >= nbytes)
				keep = 1'b0;
			if (keep)
				r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/olpht_hash.sv
// Iterative key hash: sdbm over the key bytes, one byte a cycle, then the
// product with HASH_MULT in two 32x32 steps. Depends on olpht_pkg.
`default_nettype none

module olpht_hash (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [olpht_pkg::KEY_W-1:0]  key,
	output logic                           done,
	output logic [olpht_pkg::HASH_W-1:0]   hash
);
	import olpht_pkg::*;

	hash_state_t       state_q, state_d;
	logic [KEY_W-1:0]  key_q;
	logic [2:0]        byte_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] prod_q;
	logic [HASH_W-1:0] hash_q;
	logic              done_q;
	logic [7:0]        cur_byte;
	logic [31:0]       hi_part;

	assign cur_byte = key_q[{byte_q, 3'b000} +: 8];
	assign hi_part  = acc_q[63:32] * HASH_MULT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= HS_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			HS_IDLE:   if (start) state_d = HS_BYTE;
			HS_BYTE:   if (cur_byte == 8'd0 || byte_q == 3'd7) state_d = HS_MUL_LO;
			HS_MUL_LO: state_d = HS_MUL_HI;
			HS_MUL_HI: state_d = HS_IDLE;
			default:   state_d = HS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == HS_MUL_HI);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			HS_IDLE: begin
				if (start) begin
					key_q  <= key;
					acc_q  <= '0;
					byte_q <= '0;
				end
			end
			HS_BYTE: begin
				// h = c + h * 65599, stop at the terminating zero byte
				if (cur_byte != 8'd0)
					acc_q <= {56'd0, cur_byte} + (acc_q << 6) + (acc_q << 16) - acc_q;
				byte_q <= byte_q + 3'd1;
			end
			HS_MUL_LO: prod_q <= acc_q[31:0] * HASH_MULT;
			HS_MUL_HI: hash_q <= prod_q + {hi_part, 32'd0};
			default: ;
		endcase
	end

	assign done = done_q;
	assign hash = hash_q;

endmodule

`default_nettype wire

>>> sv/ordered_linear_probe_hash_table_unit.sv
// Ordered linear-probe hash table: an accepted item is hashed (olpht_hash),
// then probes from its home slot, one slot per cycle through the entry memory
// read port, until it finds an empty slot or, on lookup, a hit. A full-table
// insert skips the probe. One item at a time; s_tready rises together with
// m_tvalid. After reset a clearing pass empties the memory with s_tready low.
// Depends on olpht_pkg and olpht_hash.
`default_nettype none

module ordered_linear_probe_hash_table_unit #(
	parameter int TABLE_SIZE = olpht_pkg::TABLE_SIZE_DEF,
	parameter int KEY_BYTES  = olpht_pkg::KEY_BYTES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [olpht_pkg::S_TDATA_W-1:0]   s_tdata,  // key[63:0], value[79:64]
	input  wire logic                              s_tuser,  // func
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [olpht_pkg::M_TDATA_W-1:0]        m_tdata,  // found_value[15:0], slot[25:16], zero
	output logic [1:0]                             m_tuser   // status
);
	import olpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int CNT_W = IDX_W + 1;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   count_q;
	func_t              func_q;
	logic [KEY_W-1:0]   ck_q;
	logic [VALUE_W-1:0] val_q;
	logic [HASH_W-1:0]  car_hash_q;
	logic [KEY_W-1:0]   car_key_q;
	logic [VALUE_W-1:0] car_val_q;
	status_t            res_status_q;
	logic [VALUE_W-1:0] res_val_q;
	logic [IDX_W-1:0]   res_slot_q;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [1:0]         m_tuser_q;

	logic               hash_start, hash_done;
	logic [HASH_W-1:0]  hash_val;

	ent_t               mem [TABLE_SIZE];
	ent_t               rd_q;
	logic               we, re;
	logic [IDX_W-1:0]   waddr, raddr;
	ent_t               wdata;

	logic               in_acc, out_load, table_full, swap, hit;
	logic [IDX_W-1:0]   home, idx_next;
	logic [SLOT_W-1:0]  slot_out;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_acc     = s_tvalid && s_tready;
	assign hash_start = in_acc;
	assign home       = car_hash_q[IDX_W-1:0];
	assign idx_next   = idx_q + IDX_W'(1);
	assign table_full = (count_q >= CNT_W'(TABLE_SIZE - 1));
	assign swap       = (car_hash_q[IDX_W-1:0] < rd_q.hash[IDX_W-1:0]);
	assign hit        = (rd_q.hash == car_hash_q) && (rd_q.key == ck_q);
	assign out_load   = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign slot_out   = SLOT_W'(res_slot_q);

	olpht_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (canon_key(s_tdata[KEY_W-1:0], KEY_BYTES)),
		.done   (hash_done),
		.hash   (hash_val)
	);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = idx_q;
		raddr   = idx_next;
		wdata   = '{used: 1'b1, hash: car_hash_q, key: car_key_q, value: car_val_q};
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				wdata = '0;
				if (idx_q == IDX_W'(TABLE_SIZE - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE:  if (in_acc) state_d = ST_HASH;
			ST_HASH:  if (hash_done) state_d = ST_START;
			ST_START: begin
				if (func_q == FUNC_INSERT && table_full) begin
					state_d = ST_OUT;
				end else begin
					re      = 1'b1;
					raddr   = home;
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (!rd_q.used) begin
					// empty slot: the carried entry lands here on insert
					we      = (func_q == FUNC_INSERT);
					state_d = ST_OUT;
				end else if (func_q == FUNC_INSERT) begin
					we = swap;
					re = 1'b1;
				end else if (hit) begin
					state_d = ST_OUT;
				end else begin
					re = 1'b1;
				end
			end
			ST_OUT:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR)
				idx_q <= idx_next;
			else if (state_q == ST_START)
				idx_q <= home;
			else if (state_q == ST_PROBE && re)
				idx_q <= idx_next;
			if (state_q == ST_PROBE && !rd_q.used && func_q == FUNC_INSERT)
				count_q <= count_q + CNT_W'(1);
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func_t'(s_tuser);
			ck_q   <= canon_key(s_tdata[KEY_W-1:0], KEY_BYTES);
			val_q  <= s_tdata[KEY_W +: VALUE_W];
		end
		if (state_q == ST_HASH && hash_done) begin
			car_hash_q <= hash_val;
			car_key_q  <= ck_q;
			car_val_q  <= val_q;
		end
		if (state_q == ST_START) begin
			res_status_q <= STAT_FULL;
			res_val_q    <= '0;
			res_slot_q   <= home;
		end
		if (state_q == ST_PROBE) begin
			if (!rd_q.used) begin
				res_status_q <= (func_q == FUNC_INSERT) ? STAT_INSERTED : STAT_NOT_FOUND;
				res_val_q    <= '0;
				res_slot_q   <= idx_q;
			end else if (func_q == FUNC_INSERT) begin
				// displaced entry probes on
				if (swap) begin
					car_hash_q <= rd_q.hash;
					car_key_q  <= rd_q.key;
					car_val_q  <= rd_q.value;
				end
			end else if (hit) begin
				res_status_q <= STAT_FOUND;
				res_val_q    <= rd_q.value;
				res_slot_q   <= idx_q;
			end
		end
		if (out_load) begin
			m_tdata_q <= {{M_PAD_W{1'b0}}, slot_out, res_val_q};
			m_tuser_q <= res_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

>>> sv/olpht_check.sv
// Port-level checks for the ordered linear-probe hash table, bound to the
// top level. Depends on olpht_pkg.
`default_nettype none

module olpht_check (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [olpht_pkg::S_TDATA_W-1:0] s_tdata,
	input wire logic                            s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [olpht_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic [1:0]                      m_tuser
);
	import olpht_pkg::*;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// one item at a time: ready drops after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// only a hit carries a payload
	a_val_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != STAT_FOUND) |-> m_tdata[VALUE_W-1:0] == '0)
		else $error("payload on a result that is not a hit");

	// a new result appears only while no item is being taken
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without an item in flight");

endmodule

bind ordered_linear_probe_hash_table_unit olpht_check u_check (.*);

`default_nettype wire

>>> tb/ordered_linear_probe_hash_table_unit_tb.sv
// Self-checking bench for ordered_linear_probe_hash_table_unit: insert and lookup items are
// streamed in with random gaps and stalls and checked against a slot-level table predictor.
// Depends on olpht_pkg and the unit itself.
`default_nettype none

module ordered_linear_probe_hash_table_unit_tb;

	localparam int          SLOTS     = olpht_pkg::TABLE_SIZE_DEF;
	localparam logic [31:0] SLOT_MASK = SLOTS - 1;
	localparam logic [63:0] GOLDEN    = 64'd2654435761;
	localparam int          REPORT_MAX = 10;

	typedef struct packed {
		olpht_pkg::func_t  func;
		logic [63:0]       key;
		logic [15:0]       value;
	} table_op_t;

	typedef struct packed {
		olpht_pkg::status_t status;
		logic [15:0]        found_value;
		logic [9:0]         slot;
	} table_reply_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;  // key[63:0], value[79:64]
	logic        s_tuser  = 1'b0; // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // found_value[15:0], slot[25:16], zero
	logic [1:0]  m_tuser;        // status

	// predictor copy of the table
	bit          slot_taken [SLOTS];
	logic [63:0] slot_name  [SLOTS];
	logic [63:0] slot_hash  [SLOTS];
	logic [15:0] slot_val   [SLOTS];
	int unsigned stored_count = 0;

	table_op_t    ops_queued[$];
	table_reply_t replies_due[$];
	logic [63:0]  names_stored[$];
	int           inserts_queued = 0;
	int           mismatch_count = 0;

	bit in_taken  = 1'b0;
	bit out_taken = 1'b0;
	bit calm_in   = 1'b0;
	bit calm_out  = 1'b0;
	int in_wait   = 0;
	int out_wait  = 0;

	ordered_linear_probe_hash_table_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// keep only the bytes ahead of the first zero byte
	function automatic logic [63:0] name_bytes(input logic [63:0] k);
		logic [63:0] r;
		bit          ended;
		r     = '0;
		ended = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (k[8*i +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction

	function automatic logic [63:0] name_hash(input logic [63:0] nm);
		logic [63:0] h;
		bit          ended;
		h     = '0;
		ended = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (nm[8*i +: 8] == 8'd0)
				ended = 1'b1;
			if (!ended)
				h = {56'd0, nm[8*i +: 8]} + (h << 6) + (h << 16) - h;
		end
		return h * GOLDEN;
	endfunction

	function automatic void table_step(input logic f, input logic [63:0] raw_key,
			input logic [15:0] val);
		logic [63:0]  nm, h, ch, ck, th, tk;
		logic [15:0]  cv, tv;
		int unsigned  idx;
		bit           hit;
		table_reply_t r;
		nm            = name_bytes(raw_key);
		h             = name_hash(nm);
		idx           = h[31:0] & SLOT_MASK;
		hit           = 1'b0;
		r.found_value = '0;
		if (f == olpht_pkg::FUNC_INSERT) begin
			if (stored_count >= SLOTS - 1) begin
				r.status = olpht_pkg::STAT_FULL;
			end else begin
				ch = h;
				ck = nm;
				cv = val;
				for (int n = 0; n < SLOTS && slot_taken[idx]; n++) begin
					// carried entry with the lower home slot takes this place
					if ((ch[31:0] & SLOT_MASK) < (slot_hash[idx][31:0] & SLOT_MASK)) begin
						th             = slot_hash[idx];
						tk             = slot_name[idx];
						tv             = slot_val[idx];
						slot_hash[idx] = ch;
						slot_name[idx] = ck;
						slot_val[idx]  = cv;
						ch             = th;
						ck             = tk;
						cv             = tv;
					end
					idx = (idx + 1) & SLOT_MASK;
				end
				slot_taken[idx] = 1'b1;
				slot_hash[idx]  = ch;
				slot_name[idx]  = ck;
				slot_val[idx]   = cv;
				stored_count++;
				r.status = olpht_pkg::STAT_INSERTED;
			end
		end else begin
			for (int n = 0; n < SLOTS && slot_taken[idx] && !hit; n++) begin
				if (slot_hash[idx] == h && slot_name[idx] == nm)
					hit = 1'b1;
				else
					idx = (idx + 1) & SLOT_MASK;
			end
			r.status = hit ? olpht_pkg::STAT_FOUND : olpht_pkg::STAT_NOT_FOUND;
			if (hit)
				r.found_value = slot_val[idx];
		end
		r.slot = idx[9:0];
		replies_due.push_back(r);
	endfunction

	function automatic void compare_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("mismatch on %s: expected %h, got %h", what, want, got);
		end
	endfunction

	// long calm stretches with no waiting, otherwise a random wait drawn per item
	function automatic int draw_wait(inout bit calm);
		if ($urandom_range(0, 63) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic logic [63:0] rand_name();
		int          len;
		bit          tiny;
		logic [63:0] k;
		tiny = ($urandom_range(0, 7) == 0);
		if (tiny)
			len = $urandom_range(1, 3);
		else if ($urandom_range(0, 31) == 0)
			len = 0;
		else
			len = $urandom_range(1, 8);
		k = {$urandom, $urandom};
		for (int i = 0; i < 8; i++) begin
			if (i < len && tiny)
				k[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
			else if (i < len && k[8*i +: 8] == 8'd0)
				k[8*i +: 8] = 8'($urandom_range(1, 255));
			else if (i == len)
				k[8*i +: 8] = 8'd0;
		end
		return k;
	endfunction

	// same name, fresh junk after the terminating zero byte
	function automatic logic [63:0] with_junk(input logic [63:0] k);
		logic [63:0] r;
		bit          ended;
		r     = {$urandom, $urandom};
		ended = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!ended) begin
				r[8*i +: 8] = k[8*i +: 8];
				if (k[8*i +: 8] == 8'd0)
					ended = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic void queue_op(input olpht_pkg::func_t f, input logic [63:0] k,
			input logic [15:0] v);
		table_op_t op;
		op.func  = f;
		op.key   = k;
		op.value = v;
		ops_queued.push_back(op);
		if (f == olpht_pkg::FUNC_INSERT) begin
			names_stored.push_back(k);
			inserts_queued++;
		end
	endfunction

	function automatic void queue_lookup();
		if (names_stored.size() != 0 && $urandom_range(0, 9) < 6)
			queue_op(olpht_pkg::FUNC_LOOKUP,
				with_junk(names_stored[$urandom_range(0, names_stored.size() - 1)]),
				16'($urandom));
		else
			queue_op(olpht_pkg::FUNC_LOOKUP, rand_name(), 16'($urandom));
	endfunction

	// sender: change at the falling edge, hold the item until it is taken
	always @(negedge clk) begin
		table_op_t op;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (s_tvalid)
				in_wait = draw_wait(calm_in);
			if (in_wait != 0) begin
				in_wait--;
				s_tvalid <= 1'b0;
			end else if (ops_queued.size() != 0) begin
				op = ops_queued.pop_front();
				s_tdata  <= {op.value, op.key};
				s_tuser  <= op.func;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall each result for a drawn number of cycles
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (out_taken)
				out_wait = draw_wait(calm_out);
			else if (m_tvalid && out_wait != 0)
				out_wait--;
			m_tready <= (out_wait == 0);
		end
	end

	always @(posedge clk) begin
		table_reply_t want;
		in_taken  <= arst_n && s_tvalid && s_tready;
		out_taken <= arst_n && m_tvalid && m_tready;
		if (arst_n && s_tvalid && s_tready)
			table_step(s_tuser, s_tdata[63:0], s_tdata[79:64]);
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("result with nothing outstanding: status %0d, tdata %h",
						m_tuser, m_tdata);
			end else begin
				want = replies_due.pop_front();
				compare_field("status", 64'(want.status), 64'(m_tuser));
				compare_field("found_value", 64'(want.found_value), 64'(m_tdata[15:0]));
				compare_field("slot", 64'(want.slot), 64'(m_tdata[25:16]));
				compare_field("padding", '0, 64'(m_tdata[31:26]));
			end
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// empty table, the empty name, extremes, duplicates and junk after the end
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'h0, 16'h0);
		queue_op(olpht_pkg::FUNC_INSERT, 64'h0, 16'h0001);
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 16'hFFFF);
		queue_op(olpht_pkg::FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
		queue_op(olpht_pkg::FUNC_INSERT, 64'h0000_0000_0000_0061, 16'h1234);
		queue_op(olpht_pkg::FUNC_INSERT, 64'hABCD_0000_0000_0061, 16'h5678);
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_0061, 16'h0);
		queue_op(olpht_pkg::FUNC_INSERT, 64'h0102_0304_0506_0708, 16'h0);
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_0708, 16'h0);
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'h0102_0304_0506_0708, 16'hFFFF);
		queue_op(olpht_pkg::FUNC_INSERT, 64'h8000_0000_0000_0001, 16'hA5A5);
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'h0000_0000_0000_0001, 16'h0);
		queue_op(olpht_pkg::FUNC_INSERT, 64'h7F7F_7F7F_7F7F_7F7F, 16'h8000);
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'h7F7F_7F7F_7F7F_7F00, 16'h0);
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'h7F7F_7F7F_7F7F_7F7F, 16'h0);

		// hold off until the unit has drained
		while (ops_queued.size() != 0 || s_tvalid || replies_due.size() != 0)
			@(posedge clk);

		for (int i = 0; i < 1000; i++) begin
			if ($urandom_range(0, 9) < 4)
				queue_op(olpht_pkg::FUNC_INSERT, rand_name(), 16'($urandom));
			else
				queue_lookup();
		end

		// fill to one empty slot, then push against the full table
		while (inserts_queued < SLOTS - 1) begin
			queue_op(olpht_pkg::FUNC_INSERT, rand_name(), 16'($urandom));
			if ($urandom_range(0, 4) == 0)
				queue_lookup();
		end
		for (int i = 0; i < 15; i++)
			queue_op(olpht_pkg::FUNC_INSERT, rand_name(), 16'($urandom));
		queue_op(olpht_pkg::FUNC_LOOKUP, 64'h0, 16'h0);
		for (int i = 0; i < 30; i++)
			queue_lookup();

		while (ops_queued.size() != 0 || s_tvalid || replies_due.size() != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);

		if (mismatch_count == 0 && replies_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
sv/olpht_pkg.sv
sv/olpht_hash.sv
sv/ordered_linear_probe_hash_table_unit.sv
sv/olpht_check.sv
tb/ordered_linear_probe_hash_table_unit_tb.sv
